/* design/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CpWidth   = 21;

  // Replacement character given for a broken sequence or a stray byte.
  localparam logic [CpWidth-1:0] ReplacementCp = 21'h00FFFD;

  // Result queue geometry. Two free entries are needed before a byte is
  // decoded, because one byte can give up to two results.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrWidth  = $clog2(FifoDepth);
  localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);

  // Decoder state carried from one byte to the next.
  typedef struct packed {
    logic [1:0]         bytes_remaining;
    logic [CpWidth-1:0] partial_value;
    logic               skipping_continuations;
  } dec_state_t;

  // One result item.
  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               end_of_text;
    logic               last_of_run;
  } result_t;

endpackage

/* design/u8d_ifs.sv */
// ----------------------------------------------------------------------------
// u8d interfaces
// Valid/ready channels for raw text bytes and for decoded code points.
// ----------------------------------------------------------------------------
interface u8d_byte_if import u8d_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ByteWidth-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8d_cp_if import u8d_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CpWidth-1:0] code_point;
  logic               end_of_text;
  logic               last_of_run;

  modport source (output valid, output code_point, output end_of_text,
                  output last_of_run, input ready);
  modport sink   (input valid, input code_point, input end_of_text,
                  input last_of_run, output ready);
endinterface

/* design/u8d_decode.sv */
// ----------------------------------------------------------------------------
// u8d_decode
// Decoder state registers and the single-byte decode step.
// ----------------------------------------------------------------------------
module u8d_decode import u8d_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [ByteWidth-1:0] in_byte,
  output logic [1:0]           res_cnt,
  output result_t              res0,
  output result_t              res1
);

  typedef struct packed {
    logic       has_res;
    result_t    res;
    dec_state_t st;
  } lead_t;

  dec_state_t state;
  dec_state_t state_next;

  // Treats a byte as the start of a character.
  function automatic lead_t take_lead(input logic [ByteWidth-1:0] b);
    lead_t l;
    l = '0;
    unique case (b) inside
      8'h00: begin
        l.has_res = 1'b1;
        l.res.end_of_text = 1'b1;
      end
      [8'h01:8'h7F]: begin
        l.has_res = 1'b1;
        l.res.code_point = {13'd0, b};
      end
      [8'hC0:8'hDF]: begin
        l.st.partial_value   = {16'd0, b[4:0]};
        l.st.bytes_remaining = 2'd1;
      end
      [8'hE0:8'hEF]: begin
        l.st.partial_value   = {17'd0, b[3:0]};
        l.st.bytes_remaining = 2'd2;
      end
      [8'hF0:8'hF7]: begin
        l.st.partial_value   = {18'd0, b[2:0]};
        l.st.bytes_remaining = 2'd3;
      end
      default: begin
        // Stray continuation byte or a byte of 0xF8 and above.
        l.has_res = 1'b1;
        l.res.code_point = ReplacementCp;
        l.st.skipping_continuations = 1'b1;
      end
    endcase
    return l;
  endfunction

  lead_t              lead;
  logic               is_cont;
  logic [CpWidth-1:0] shifted;
  logic [1:0]         rem_dec;

  always_comb begin
    lead    = take_lead(in_byte);
    is_cont = (in_byte[7:6] == 2'b10);
    shifted = {state.partial_value[CpWidth-7:0], in_byte[5:0]};
    rem_dec = state.bytes_remaining - 2'd1;

    state_next = state;
    res_cnt    = 2'd0;
    res0       = '0;
    res1       = '0;

    if (state.bytes_remaining != 2'd0) begin
      if (is_cont) begin
        state_next.bytes_remaining = rem_dec;
        if (rem_dec == 2'd0) begin
          res_cnt = 2'd1;
          res0.code_point  = shifted;
          res0.last_of_run = 1'b1;
          state_next.partial_value = '0;
        end else begin
          state_next.partial_value = shifted;
        end
      end else begin
        // Broken sequence: replacement first, then the byte as a lead.
        res0.code_point = ReplacementCp;
        state_next      = lead.st;
        if (lead.has_res) begin
          res_cnt = 2'd2;
          res1 = lead.res;
          res1.last_of_run = 1'b1;
        end else begin
          res_cnt = 2'd1;
          res0.last_of_run = 1'b1;
        end
      end
    end else if (!(state.skipping_continuations && is_cont)) begin
      state_next = lead.st;
      if (lead.has_res) begin
        res_cnt = 2'd1;
        res0 = lead.res;
        res0.last_of_run = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  a_not_both: assert property (@(posedge clk) disable iff (rst)
    !(state.bytes_remaining != 2'd0 && state.skipping_continuations))
    else $error("skipping while a sequence is open");

  a_pv_fits3: assert property (@(posedge clk) disable iff (rst)
    state.bytes_remaining == 2'd3 |-> state.partial_value[CpWidth-1:3] == '0)
    else $error("partial value too wide for three pending bytes");

  a_pair_repl: assert property (@(posedge clk) disable iff (rst)
    (step && res_cnt == 2'd2) |-> res0.code_point == ReplacementCp)
    else $error("first of two results is not the replacement character");

endmodule

/* design/u8d_res_fifo.sv */
// ----------------------------------------------------------------------------
// u8d_res_fifo
// Small result queue taking up to two results per cycle, giving one.
// ----------------------------------------------------------------------------
module u8d_res_fifo import u8d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic [1:0] push_cnt,
  input  result_t   push0,
  input  result_t   push1,
  output logic      room,
  u8d_cp_if.source  points
);

  result_t             mem [FifoDepth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] count;
  logic [CntWidth-1:0] count_next;
  logic                pop;
  logic [PtrWidth-1:0] wr_ptr1;

  assign pop     = points.valid && points.ready;
  assign wr_ptr1 = wr_ptr + PtrWidth'(1);
  assign room    = (count <= CntWidth'(FifoDepth - 2));

  assign points.valid       = (count != '0);
  assign points.code_point  = mem[rd_ptr].code_point;
  assign points.end_of_text = mem[rd_ptr].end_of_text;
  assign points.last_of_run = mem[rd_ptr].last_of_run;

  assign count_next = count + CntWidth'(push_cnt) - CntWidth'(pop);

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrWidth'(push_cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + PtrWidth'(1);
      end
      count <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_cnt != 2'd0) |-> room)
    else $error("result pushed without room in the queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntWidth'(FifoDepth))
    else $error("result queue count out of range");

endmodule

/* design/utf8_to_codepoint_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Decodes a UTF-8 byte stream into code points with U+FFFD replacement.
// ----------------------------------------------------------------------------
// Path: a byte accepted into the input register is decoded from it and
// written into the result queue once the queue has room for two results;
// its first result is then offered on the output channel from the queue.
// Throughput: one byte per cycle while the queue has room; a byte giving
// two results hands them out in turn through the one-result-per-cycle read
// port of the result queue. The input stalls while a byte is held and more
// than two results wait in the queue.
// Reset (rst, synchronous): empties the input register and the result queue
// and returns the decoder to idle between characters.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder import u8d_pkg::*; (
  input logic       clk,
  input logic       rst,
  u8d_byte_if.sink  text,
  u8d_cp_if.source  points
);

  // Input register. A request is taken when the register is empty or is
  // being decoded in this cycle, so bytes flow back to back while room is high.
  logic                 byte_valid;
  logic [ByteWidth-1:0] byte_q;
  logic                 advance;
  logic                 room;
  logic                 take;

  logic [1:0] res_cnt;
  result_t    res0;
  result_t    res1;
  logic [1:0] push_cnt;

  // The held byte is decoded once the queue can absorb two results, which
  // covers the broken-sequence case where one byte gives two.
  assign advance    = byte_valid && room;
  assign text.ready = !byte_valid || advance;
  assign take       = text.valid && text.ready;
  assign push_cnt   = advance ? res_cnt : 2'd0;

  always_ff @(posedge clk) begin
    if (take) begin
      byte_q <= text.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (take) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  // Decode step: state registers plus the combinational byte decode.
  u8d_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (byte_q),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  // Result queue: decouples the output handshake from decoding.
  u8d_res_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (room),
    .points   (points)
  );

  a_take_frees: assert property (@(posedge clk) disable iff (rst)
    (take && byte_valid) |-> advance)
    else $error("new byte taken over an undecoded one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !points.valid)
    else $error("output valid right after reset");

endmodule
